// ===== src/utf16_to_utf8_bounded_encoder_top_defines.svh =====
// Assertion helpers shared by the encoder RTL.
`ifndef UTF16_TO_UTF8_BOUNDED_ENCODER_TOP_DEFINES_SVH
`define UTF16_TO_UTF8_BOUNDED_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define U16U8E_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expr must never be true outside reset
`define U16U8E_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define U16U8E_ASSERT(lbl, clk, rst, prop, msg)
`define U16U8E_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== src/u16u8e_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package u16u8e_pkg;

  localparam int unsigned UNIT_W          = 16;
  localparam int unsigned CFG_W           = 17;
  localparam int unsigned USED_W          = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [UNIT_W-1:0] ASCII_LIMIT = 16'h0080;
  localparam logic [UNIT_W-1:0] TWO_LIMIT   = 16'h0800;
  localparam logic [UNIT_W-1:0] HIGH_FIRST  = 16'hD800;
  localparam logic [UNIT_W-1:0] HIGH_LAST   = 16'hDBFF;
  localparam logic [UNIT_W-1:0] LOW_FIRST   = 16'hDC00;
  localparam logic [UNIT_W-1:0] LOW_LAST    = 16'hDFFF;

  localparam logic [7:0] LEAD4_MARK = 8'hF0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] QMARK      = 8'h3F;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  // One burst of output bytes caused by one code unit; bytes[0] goes first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            term;
  } job_t;

endpackage
`default_nettype wire

// ===== src/u16u8e_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_bounded_encoder_top_defines.svh"
module u16u8e_front
  import u16u8e_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [UNIT_W-1:0] code_unit,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  buffer_bytes,
  output logic              q_push,
  output job_t              q_job,
  input  logic              q_full
);

  logic [USED_W-1:0] cap;
  logic [USED_W-1:0] used, used_next;
  logic [UNIT_W-1:0] pending_high, pending_high_next;
  logic              pending_valid, pending_valid_next;
  logic              stopped, stopped_next;

  logic              accept;
  logic [USED_W:0]   slack;
  logic              is_ascii, is_two, is_high, is_low;
  logic [2:0][7:0]   enc;
  logic [1:0]        enc_n;
  logic              pfx;
  logic [2:0]        total_n;
  logic [4:0]        plane;
  job_t              job;
  logic              job_ok;

  // room left for content; top bit set when the buffer was shrunk under use
  function automatic logic fits(input logic [USED_W:0] sl, input logic [2:0] n);
    fits = !sl[USED_W] && (sl[USED_W-1:0] >= USED_W'(n));
  endfunction

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;
  assign slack     = {1'b0, cap} - {1'b0, used};

  always_comb begin
    is_ascii = code_unit < ASCII_LIMIT;
    is_two   = !is_ascii && (code_unit < TWO_LIMIT);
    is_high  = code_unit inside {[HIGH_FIRST:HIGH_LAST]};
    is_low   = code_unit inside {[LOW_FIRST:LOW_LAST]};
    enc      = '0;
    enc_n    = 2'd0;
    if (is_ascii) begin
      enc[0] = code_unit[7:0];
      enc_n  = 2'd1;
    end else if (is_two) begin
      enc[0] = LEAD2_MARK | {3'b000, code_unit[10:6]};
      enc[1] = CONT_MARK | {2'b00, code_unit[5:0]};
      enc_n  = 2'd2;
    end else if (is_high) begin
      enc_n  = 2'd0;
    end else if (is_low) begin
      enc[0] = QMARK;
      enc_n  = 2'd1;
    end else begin
      enc[0] = LEAD3_MARK | {4'b0000, code_unit[15:12]};
      enc[1] = CONT_MARK | {2'b00, code_unit[11:6]};
      enc[2] = CONT_MARK | {2'b00, code_unit[5:0]};
      enc_n  = 2'd3;
    end
  end

  always_comb begin
    used_next          = used;
    pending_high_next  = pending_high;
    pending_valid_next = pending_valid;
    stopped_next       = stopped;
    job                = '0;
    job_ok             = 1'b0;
    pfx                = pending_valid;
    total_n            = {2'b00, pfx} + {1'b0, enc_n};
    plane              = {1'b0, pending_high[9:6]} + 5'd1;
    if (accept) begin
      if (code_unit == '0) begin
        // end of string: owed '?' if it fits, then the NUL
        job_ok = 1'b1;
        job.term = 1'b1;
        if (pending_valid && !stopped && fits(slack, 3'd1)) begin
          job.bytes[0] = QMARK;
          job.bytes[1] = NUL_BYTE;
          job.last_idx = 2'd1;
        end else begin
          job.bytes[0] = NUL_BYTE;
          job.last_idx = 2'd0;
        end
        used_next          = '0;
        pending_valid_next = 1'b0;
        stopped_next       = 1'b0;
      end else if (!stopped) begin
        pending_valid_next = 1'b0;
        if (pending_valid && is_low) begin
          if (fits(slack, 3'd4)) begin
            job_ok       = 1'b1;
            job.bytes[0] = LEAD4_MARK | {5'b00000, plane[4:2]};
            job.bytes[1] = CONT_MARK | {2'b00, plane[1:0], pending_high[5:2]};
            job.bytes[2] = CONT_MARK | {2'b00, pending_high[1:0], code_unit[9:6]};
            job.bytes[3] = CONT_MARK | {2'b00, code_unit[5:0]};
            job.last_idx = 2'd3;
            used_next    = used + USED_W'(4);
          end else begin
            stopped_next = 1'b1;
          end
        end else if (pfx && !fits(slack, 3'd1)) begin
          stopped_next = 1'b1;
        end else if (is_high) begin
          pending_valid_next = 1'b1;
          pending_high_next  = code_unit;
          if (pfx) begin
            job_ok       = 1'b1;
            job.bytes[0] = QMARK;
            job.last_idx = 2'd0;
            used_next    = used + USED_W'(1);
          end
        end else if (fits(slack, total_n)) begin
          job_ok       = 1'b1;
          job.bytes    = pfx ? {enc, QMARK} : {NUL_BYTE, enc};
          job.last_idx = 2'(total_n - 3'd1);
          used_next    = used + USED_W'(total_n);
        end else begin
          // character does not fit; the broken-pair '?' still goes out
          stopped_next = 1'b1;
          if (pfx) begin
            job_ok       = 1'b1;
            job.bytes[0] = QMARK;
            job.last_idx = 2'd0;
            used_next    = used + USED_W'(1);
          end
        end
      end
    end
  end

  assign q_push = accept && job_ok;
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap           <= USED_W'(255);
      used          <= '0;
      pending_valid <= 1'b0;
      stopped       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (buffer_bytes[CFG_W-1]) begin
          cap <= '1;
        end else if (buffer_bytes == '0) begin
          cap <= '0;
        end else begin
          cap <= buffer_bytes[USED_W-1:0] - USED_W'(1);
        end
      end
      used          <= used_next;
      pending_valid <= pending_valid_next;
      stopped       <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    pending_high <= pending_high_next;
  end

  `U16U8E_ASSERT(a_stop_clears_pending, clk, rst, stopped |-> !pending_valid, "pending while stopped")

endmodule
`default_nettype wire

// ===== src/u16u8e_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_bounded_encoder_top_defines.svh"
module u16u8e_queue
  import u16u8e_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `U16U8E_NEVER(a_q_overflow, clk, rst, push && full && !pop, "job queue overflow")
  `U16U8E_NEVER(a_q_underflow, clk, rst, pop && empty, "job queue underflow")

endmodule
`default_nettype wire

// ===== src/u16u8e_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_bounded_encoder_top_defines.svh"
module u16u8e_back
  import u16u8e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  job_t       q_head,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last_in_run,
  output logic       is_terminator
);

  logic [1:0] idx;
  logic       out_valid;
  logic       advance;
  logic       at_last;

  // next byte loads when the output slot is free or being drained this edge
  assign advance = !q_empty && (!out_valid || pop);
  assign at_last = (idx == q_head.last_idx);
  assign q_pop   = advance && at_last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte      <= q_head.bytes[idx];
      last_in_run   <= at_last;
      is_terminator <= at_last && q_head.term;
    end
  end

  `U16U8E_ASSERT(a_idx_in_job, clk, rst, !q_empty |-> (idx <= q_head.last_idx), "byte index past job")
  `U16U8E_ASSERT(a_term_is_nul, clk, rst, (out_valid && is_terminator) |-> (out_byte == NUL_BYTE && last_in_run), "bad terminator")

endmodule
`default_nettype wire

// ===== src/utf16_to_utf8_bounded_encoder_top.sv =====
// UTF-16 to UTF-8 encoder with a bounded output. Code units enter on push/full
// and UTF-8 bytes leave on empty/pop, one byte per beat; last_in_run marks the
// final byte caused by a unit and is_terminator the NUL that a zero unit emits.
// A unit is taken every cycle while the job queue has room; each unit makes
// 0 to 4 output bytes, so with pop held high and jobs queued the
// sustained rate is one byte per cycle, set by the single-byte output register.
// A unit's job is queued when taken and its first byte then goes to the output
// register. The limit buffer_bytes counts the closing NUL and may be written at
// any idle time; cfg_ready is always high. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module utf16_to_utf8_bounded_encoder_top
  import u16u8e_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF  // jobs buffered front to back
) (
  input  logic              clk,
  input  logic              rst,
  // code unit input
  input  logic              push,
  output logic              full,
  input  logic [UNIT_W-1:0] code_unit,
  // byte output
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte,
  output logic              last_in_run,
  output logic              is_terminator,
  // buffer size register
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  buffer_bytes
);

  // front -> queue
  logic q_push;
  job_t q_wr_job;
  logic q_full;
  // queue -> back
  logic q_pop;
  job_t q_head;
  logic q_empty;

  // Front: classifies each unit, tracks the surrogate and fill state, and
  // turns the unit into at most one job of up to four bytes.
  u16u8e_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .code_unit    (code_unit),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .buffer_bytes (buffer_bytes),
    .q_push       (q_push),
    .q_job        (q_wr_job),
    .q_full       (q_full)
  );

  // Short job queue so a stalled consumer does not stop the front at once.
  u16u8e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (q_wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .head   (q_head),
    .empty  (q_empty)
  );

  // Back: walks the head job one byte per beat into the output register.
  u16u8e_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .last_in_run   (last_in_run),
    .is_terminator (is_terminator)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import u16u8e_pkg::*;

  // One output beat as the checker sees it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       term;
  } utf8_beat_t;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int GAP_PCT       = 14;    // idle chance per cycle, percent
  localparam int HOLD_CYCLES   = 150;   // long pop hold-off that backs the block up
  localparam int SETTLE_CYCLES = 8;     // quiet time after the last byte is seen, with margin
  localparam int STALL_LIMIT   = 1000;  // cycles without any beat before giving up
  localparam int BUF_RESET     = 256;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              push          = 1'b0;
  logic              full;
  logic [UNIT_W-1:0] code_unit     = '0;
  logic              empty;
  logic              pop           = 1'b0;
  logic [7:0]        out_byte;
  logic              last_in_run;
  logic              is_terminator;
  logic              cfg_valid     = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  buffer_bytes  = '0;

  always #HALF_PERIOD clk = ~clk;

  utf16_to_utf8_bounded_encoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .code_unit    (code_unit),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .last_in_run  (last_in_run),
    .is_terminator(is_terminator),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .buffer_bytes (buffer_bytes)
  );

  // ---------------------------------------------------------------------------
  // Encoder shadow: buffer size, string progress and the held high surrogate.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]  buf_limit  = CFG_W'(BUF_RESET);
  int unsigned       used_bytes = 0;
  logic [UNIT_W-1:0] held_high  = '0;
  logic              held_ok    = 1'b0;
  logic              halted     = 1'b0;

  utf8_beat_t        run[$];            // bytes caused by the unit being encoded
  utf8_beat_t        utf8_expected[$];  // bytes still owed by the block, oldest first
  logic [UNIT_W-1:0] utf16_pending[$];  // units not yet taken by the block

  // Stimulus shaping, written by the sequence only.
  bit steady   = 1'b0;  // no idling on either side
  bit hold_arm = 1'b0;  // ask the byte side for its long hold-off

  int beat_errs = 0;

  // content bytes allowed per string; the NUL is not counted
  function automatic int unsigned content_room();
    int unsigned b;
    b = buf_limit;
    if (b == 0) b = 1;
    if (b > 65536) b = 65536;
    return b - 1;
  endfunction

  function automatic bit room_for(int unsigned n);
    return used_bytes + n <= content_room();
  endfunction

  function automatic void put(logic [7:0] b, logic term);
    utf8_beat_t bt;
    bt.data = b;
    bt.last = 1'b0;
    bt.term = term;
    run.push_back(bt);
  endfunction

  // character did not fit: drop everything until the string ends
  function automatic void give_up();
    halted    = 1'b1;
    held_ok   = 1'b0;
    held_high = '0;
  endfunction

  // one unit that neither ends the string nor completes a pair
  function automatic void encode_single(logic [UNIT_W-1:0] c);
    if (c < ASCII_LIMIT) begin
      if (!room_for(1)) begin
        give_up();
      end else begin
        put(c[7:0], 1'b0);
        used_bytes += 1;
      end
    end else if (c < TWO_LIMIT) begin
      if (!room_for(2)) begin
        give_up();
      end else begin
        put(LEAD2_MARK | {3'b000, c[10:6]}, 1'b0);
        put(CONT_MARK | {2'b00, c[5:0]}, 1'b0);
        used_bytes += 2;
      end
    end else if (c >= HIGH_FIRST && c <= HIGH_LAST) begin
      held_high = c;
      held_ok   = 1'b1;
    end else if (c >= LOW_FIRST && c <= LOW_LAST) begin
      // low surrogate with nothing before it
      if (!room_for(1)) begin
        give_up();
      end else begin
        put(QMARK, 1'b0);
        used_bytes += 1;
      end
    end else begin
      if (!room_for(3)) begin
        give_up();
      end else begin
        put(LEAD3_MARK | {4'b0000, c[15:12]}, 1'b0);
        put(CONT_MARK | {2'b00, c[11:6]}, 1'b0);
        put(CONT_MARK | {2'b00, c[5:0]}, 1'b0);
        used_bytes += 3;
      end
    end
  endfunction

  // Expected bytes for one accepted unit, appended to utf8_expected.
  function automatic void utf8_predict(logic [UNIT_W-1:0] c);
    logic [UNIT_W-1:0] h;
    logic [4:0]        plane;
    utf8_beat_t        tail;
    run.delete();
    if (c == '0) begin
      // owed '?' for a dangling high surrogate, then the NUL
      if (held_ok && !halted && room_for(1)) put(QMARK, 1'b0);
      put(NUL_BYTE, 1'b1);
      used_bytes = 0;
      held_high  = '0;
      held_ok    = 1'b0;
      halted     = 1'b0;
    end else if (!halted) begin
      if (held_ok) begin
        h         = held_high;
        held_ok   = 1'b0;
        held_high = '0;
        if (c >= LOW_FIRST && c <= LOW_LAST) begin
          if (!room_for(4)) begin
            give_up();
          end else begin
            plane = {1'b0, h[9:6]} + 5'd1;
            put(LEAD4_MARK | {5'b00000, plane[4:2]}, 1'b0);
            put(CONT_MARK | {2'b00, plane[1:0], h[5:2]}, 1'b0);
            put(CONT_MARK | {2'b00, h[1:0], c[9:6]}, 1'b0);
            put(CONT_MARK | {2'b00, c[5:0]}, 1'b0);
            used_bytes += 4;
          end
        end else if (!room_for(1)) begin
          give_up();
        end else begin
          // broken pair: '?' for the high half, then the unit on its own
          put(QMARK, 1'b0);
          used_bytes += 1;
          encode_single(c);
        end
      end else begin
        encode_single(c);
      end
    end
    used_bytes &= 32'hFFFF;
    if (run.size() != 0) begin
      tail      = run.pop_back();
      tail.last = 1'b1;
      run.push_back(tail);
    end
    foreach (run[i]) utf8_expected.push_back(run[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Unit driver: offers the head of utf16_pending, predicts on each accepted beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        utf8_predict(code_unit);
        utf16_pending.delete(0);
      end
      if (utf16_pending.size() != 0 && (steady || $urandom_range(99) >= GAP_PCT)) begin
        push      <= 1'b1;
        code_unit <= utf16_pending[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte monitor: checks each popped beat against the oldest expectation.
  // The hold-off is counted here so the unit side keeps pushing into a full block.
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin : byte_mon
    utf8_beat_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (utf8_expected.size() == 0) begin
          $display("%0t: byte %h last %b term %b with nothing expected",
                   $time, out_byte, last_in_run, is_terminator);
          beat_errs++;
        end else begin
          want = utf8_expected.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
            beat_errs++;
          end
          if (last_in_run !== want.last) begin
            $display("%0t: last_in_run expected %b actual %b", $time, want.last,
                     last_in_run);
            beat_errs++;
          end
          if (is_terminator !== want.term) begin
            $display("%0t: is_terminator expected %b actual %b", $time, want.term,
                     is_terminator);
            beat_errs++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else if (hold_arm && !hold_done) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        pop       <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(99) >= GAP_PCT);
      end
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  int unsigned stall_cnt = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------

  // wait for every unit taken and every byte seen, then let the pipe go quiet
  task automatic settle();
    do @(negedge clk);
    while (utf16_pending.size() != 0 || utf8_expected.size() != 0 || push);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_buffer(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid    <= 1'b1;
    buffer_bytes <= v;
    do @(posedge clk);
    while (!cfg_ready);
    buf_limit  = v;
    cfg_valid <= 1'b0;
  endtask

  // Random text: mostly well-formed characters and pairs, some broken pairs,
  // stray halves, raw 16-bit noise and string ends.
  task automatic add_text(int n, bit close);
    int unsigned k;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 6) begin
        utf16_pending.push_back('0);
      end else if (k < 26) begin
        utf16_pending.push_back(UNIT_W'($urandom_range(1, 127)));
      end else if (k < 40) begin
        utf16_pending.push_back(UNIT_W'($urandom_range(128, 2047)));
      end else if (k < 48) begin
        utf16_pending.push_back(UNIT_W'($urandom_range(16'h0800, 16'hD7FF)));
      end else if (k < 55) begin
        utf16_pending.push_back(UNIT_W'($urandom_range(16'hE000, 16'hFFFF)));
      end else if (k < 75) begin
        utf16_pending.push_back(UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST)));
        utf16_pending.push_back(UNIT_W'($urandom_range(LOW_FIRST, LOW_LAST)));
      end else if (k < 81) begin
        utf16_pending.push_back(UNIT_W'($urandom_range(LOW_FIRST, LOW_LAST)));
      end else if (k < 86) begin
        utf16_pending.push_back(UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST)));
      end else begin
        utf16_pending.push_back(UNIT_W'($urandom_range(16'hFFFF)));
      end
    end
    if (close) utf16_pending.push_back('0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    logic [CFG_W-1:0] sizes [10];
    sizes = '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd7, 17'd10,
              17'd65536, 17'h1FFFF};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed, at the reset buffer size: each encoding length at its edges,
    // pairs at both extremes, stray low half, broken pairs of several kinds,
    // a string end with a high half still held.
    @(negedge clk);
    utf16_pending.push_back(16'h0001);
    utf16_pending.push_back(16'h007F);
    utf16_pending.push_back(16'h0080);
    utf16_pending.push_back(16'h07FF);
    utf16_pending.push_back(16'h0800);
    utf16_pending.push_back(16'hE000);
    utf16_pending.push_back(16'hFFFF);
    utf16_pending.push_back(HIGH_FIRST);
    utf16_pending.push_back(LOW_FIRST);
    utf16_pending.push_back(HIGH_LAST);
    utf16_pending.push_back(LOW_LAST);
    utf16_pending.push_back(LOW_FIRST);
    utf16_pending.push_back(16'hD83D);   // high then ASCII
    utf16_pending.push_back(16'h0041);
    utf16_pending.push_back(HIGH_FIRST); // high then high, second stays held
    utf16_pending.push_back(HIGH_FIRST);
    utf16_pending.push_back(16'h0000);   // owes '?' before the NUL
    utf16_pending.push_back(16'hD801);   // high then 3-byte: four bytes from one unit
    utf16_pending.push_back(16'h0800);
    utf16_pending.push_back(16'h0000);
    // open string left behind for the shrink below
    utf16_pending.push_back(16'h0042);
    utf16_pending.push_back(16'h0043);
    utf16_pending.push_back(16'h0044);
    utf16_pending.push_back(16'h0045);
    settle();

    // buffer shrunk below what is already used: only the NUL gets out
    set_buffer(17'd3);
    @(negedge clk);
    utf16_pending.push_back(16'h0046);
    utf16_pending.push_back(16'h0000);
    settle();

    // Random phases over small, zero and oversized buffers. Strings are
    // sometimes left open so the next size acts on a half-used buffer.
    foreach (sizes[i]) begin
      set_buffer(sizes[i]);
      add_text(3, $urandom_range(1));
      settle();
    end
    set_buffer(CFG_W'($urandom_range(1, 40)));
    add_text(4, 1'b1);
    settle();

    // back-pressure: pops held off long enough for pushes to stall on full
    set_buffer(CFG_W'(BUF_RESET));
    hold_arm = 1'b1;
    add_text(12, 1'b1);
    settle();
    hold_arm = 1'b0;

    // no idling on either side
    set_buffer(17'd65536);
    steady = 1'b1;
    add_text(16, 1'b1);
    settle();
    steady = 1'b0;

    if (beat_errs == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/u16u8e_pkg.sv
src/u16u8e_front.sv
src/u16u8e_queue.sv
src/u16u8e_back.sv
src/utf16_to_utf8_bounded_encoder_top.sv
tb/sv/tb_top.sv
